FILE: sv/sosf_pkg.sv
// Shared constants, types and result structs for the sonar scan outlier filter.
// Used by sosf_sorter, sosf_divider and sonar_scan_outlier_filter_core.
`default_nettype none

package sosf_pkg;

  localparam int unsigned WINDOW   = 5;
  localparam int unsigned DIST_W   = 12;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned DIST_MAX = (1 << DIST_W) - 1;

  // Count of samples in the window, 0 to WINDOW inclusive.
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W    = $clog2(WINDOW * DIST_MAX + 1);
  // q3 + 2 * (q3 - q1 + 1) stays below 3 * 2^DIST_W.
  localparam int unsigned LIMIT_W  = DIST_W + 2;

  localparam int unsigned Q1_IDX   = WINDOW / 4;
  localparam int unsigned Q3_IDX   = (WINDOW * 3) / 4;
  localparam int unsigned MID_IDX  = WINDOW / 2;

  // Bubble passes run 0 to WINDOW-2, steps within a pass 0 to WINDOW.
  localparam int unsigned PASS_W   = $clog2(WINDOW - 1);
  localparam int unsigned STEP_W   = $clog2(WINDOW + 1);
  localparam int unsigned DSTEP_W  = $clog2(SUM_W + 1);

  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } sosf_acc_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } sosf_div_t;

endpackage

`default_nettype wire

FILE: sv/sosf_sorter.sv
// Sorts the window distances with one shared comparator on a rotating register line,
// then sums and counts the distances at or below the outlier limit. Uses sosf_pkg.
`default_nettype none

module sosf_sorter import sosf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  dist_t [WINDOW-1:0]      dist_i,
  output sosf_acc_t               acc_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SORT  = 3'd1;
  localparam logic [2:0] S_LIMIT = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic [STEP_W-1:0]   step_q, step_d;
  dist_t [WINDOW-1:0]  s_q, s_d;
  dist_t               c_q, c_d;
  logic [LIMIT_W-1:0]  limit_q, limit_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [LIMIT_W-1:0]  cmp_a, cmp_b;
  logic                a_le_b;
  dist_t               lo, hi;
  dist_t [WINDOW-1:0]  s_rot;
  logic [LIMIT_W-1:0]  q_span, limit_calc;

  // The one comparator: carry against the head while sorting, head against the
  // limit while summing.
  always_comb begin
    if (state_q == S_SUM) begin
      cmp_a = LIMIT_W'(s_q[0]);
      cmp_b = limit_q;
    end else begin
      cmp_a = LIMIT_W'(c_q);
      cmp_b = LIMIT_W'(s_q[0]);
    end
    a_le_b = (cmp_a <= cmp_b);
    lo     = a_le_b ? c_q : s_q[0];
    hi     = a_le_b ? s_q[0] : c_q;
  end

  always_comb begin
    for (int i = 0; i < WINDOW - 1; i++) begin
      s_rot[i] = s_q[i+1];
    end
    s_rot[WINDOW-1] = s_q[0];
  end

  assign q_span     = LIMIT_W'(s_q[Q3_IDX]) - LIMIT_W'(s_q[Q1_IDX]) + LIMIT_W'(1);
  assign limit_calc = LIMIT_W'(s_q[Q3_IDX]) + (q_span << 1);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    step_d  = step_q;
    s_d     = s_q;
    c_d     = c_q;
    limit_d = limit_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          s_d     = dist_i;
          pass_d  = '0;
          step_d  = '0;
          state_d = S_SORT;
        end
      end
      S_SORT: begin
        // One bubble pass: pick up the head as carry, let the larger value ride
        // along while the smaller drops to the tail, then park the carry last.
        s_d = s_rot;
        if (step_q == '0) begin
          c_d = s_q[0];
        end else if (step_q == STEP_W'(WINDOW)) begin
          s_d[WINDOW-1] = c_q;
        end else begin
          s_d[WINDOW-1] = lo;
          c_d           = hi;
        end
        if (step_q == STEP_W'(WINDOW)) begin
          step_d = '0;
          if (pass_q == PASS_W'(WINDOW - 2)) begin
            state_d = S_LIMIT;
          end else begin
            pass_d = pass_q + PASS_W'(1);
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_LIMIT: begin
        limit_d = limit_calc;
        sum_d   = '0;
        cnt_d   = '0;
        step_d  = '0;
        state_d = S_SUM;
      end
      S_SUM: begin
        s_d = s_rot;
        if (a_le_b) begin
          sum_d = sum_q + SUM_W'(s_q[0]);
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (step_q == STEP_W'(WINDOW - 1)) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    c_q     <= c_d;
    limit_q <= limit_d;
    sum_q   <= sum_d;
    cnt_q   <= cnt_d;
  end

  assign acc_o.done = (state_q == S_DONE);
  assign acc_o.sum  = sum_q;
  assign acc_o.cnt  = cnt_q;

endmodule

`default_nettype wire

FILE: sv/sosf_divider.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Uses sosf_pkg for operand widths and the result struct.
`default_nettype none

module sosf_divider import sosf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output sosf_div_t        div_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DSTEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]   quot_q, quot_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   dvs_q, dvs_d;

  logic [CNT_W:0]     trial, rem_next;
  logic               fits;

  // The remainder stays below the divisor, so it fits back into CNT_W bits.
  assign trial    = {rem_q, quot_q[SUM_W-1]};
  assign fits     = (trial >= {1'b0, dvs_q});
  assign rem_next = fits ? (trial - {1'b0, dvs_q}) : trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[SUM_W-2:0], fits};
      rem_d  = rem_next[CNT_W-1:0];
      if (step_q == DSTEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + DSTEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign div_o.done = done_q;
  assign div_o.quot = quot_q;

endmodule

`default_nettype wire

FILE: sv/sonar_scan_outlier_filter_core.sv
// While the window fills, a result beat passes from T_IDLE through T_RES into the output register;
// once it is full, the sample also passes T_LOAD, the bubble sort on the sorter's single comparator
// and the bit-serial divider before T_RES.
// The block takes no new sample until the result is registered and it is back in T_IDLE; a held
// result beat stalls the block only once the next result is ready.
// Reset (asynchronous, active low) clears the window, fill count, best result and control.
`default_nettype none

module sonar_scan_outlier_filter_core import sosf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              new_scan_i,
  input  logic [7:0]        angle_i,
  input  logic [11:0]       distance_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              filtered_valid_o,
  output logic [11:0]       filtered_distance_o,
  output logic [7:0]        best_angle_o,
  output logic [11:0]       best_distance_o
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_LOAD = 3'd1;
  localparam logic [2:0] T_SORT = 3'd2;
  localparam logic [2:0] T_DIV  = 3'd3;
  localparam logic [2:0] T_RES  = 3'd4;

  logic [2:0]          state_q, state_d;
  angle_t [WINDOW-1:0] win_ang_q, win_ang_d;
  dist_t  [WINDOW-1:0] win_dist_q, win_dist_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  angle_t              best_ang_q, best_ang_d;
  dist_t               best_dist_q, best_dist_d;
  logic                fvalid_q, fvalid_d;
  dist_t               filt_q, filt_d;

  logic                out_valid_q, out_valid_d;
  logic                ofv_q, ofv_d;
  dist_t               ofd_q, ofd_d;
  angle_t              oba_q, oba_d;
  dist_t               obd_q, obd_d;

  logic                accept;
  logic                out_free;
  logic                sort_start, div_start;
  logic [CNT_W-1:0]    fill_base;
  sosf_acc_t           acc;
  sosf_div_t           div;

  assign accept     = in_valid_i && (state_q == T_IDLE);
  assign in_stall_o = (state_q != T_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fill_base  = new_scan_i ? '0 : fill_q;

  always_comb begin
    state_d     = state_q;
    win_ang_d   = win_ang_q;
    win_dist_d  = win_dist_q;
    fill_d      = fill_q;
    best_ang_d  = best_ang_q;
    best_dist_d = best_dist_q;
    fvalid_d    = fvalid_q;
    filt_d      = filt_q;
    out_valid_d = out_valid_q && out_stall_i;
    ofv_d       = ofv_q;
    ofd_d       = ofd_q;
    oba_d       = oba_q;
    obd_d       = obd_q;
    sort_start  = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          if (new_scan_i) begin
            win_ang_d   = '0;
            win_dist_d  = '0;
            best_ang_d  = '0;
            best_dist_d = '0;
          end
          if (fill_base == CNT_W'(WINDOW)) begin
            // Full window: drop the oldest sample, the new one enters last.
            for (int i = 0; i < WINDOW - 1; i++) begin
              win_ang_d[i]  = win_ang_q[i+1];
              win_dist_d[i] = win_dist_q[i+1];
            end
            win_ang_d[WINDOW-1]  = angle_i;
            win_dist_d[WINDOW-1] = distance_i;
            fill_d               = CNT_W'(WINDOW);
          end else begin
            for (int i = 0; i < WINDOW; i++) begin
              if (fill_base == CNT_W'(i)) begin
                win_ang_d[i]  = angle_i;
                win_dist_d[i] = distance_i;
              end
            end
            fill_d = fill_base + CNT_W'(1);
          end
          if ((fill_base == CNT_W'(WINDOW)) || (fill_base == CNT_W'(WINDOW - 1))) begin
            state_d = T_LOAD;
          end else begin
            fvalid_d = 1'b0;
            filt_d   = '0;
            state_d  = T_RES;
          end
        end
      end
      T_LOAD: begin
        sort_start = 1'b1;
        state_d    = T_SORT;
      end
      T_SORT: begin
        if (acc.done) begin
          div_start = 1'b1;
          state_d   = T_DIV;
        end
      end
      T_DIV: begin
        if (div.done) begin
          fvalid_d = 1'b1;
          filt_d   = div.quot[DIST_W-1:0];
          state_d  = T_RES;
        end
      end
      T_RES: begin
        if (out_free) begin
          // A tie with the best does not replace it.
          if (fvalid_q && (filt_q > best_dist_q)) begin
            best_dist_d = filt_q;
            best_ang_d  = win_ang_q[MID_IDX];
          end
          out_valid_d = 1'b1;
          ofv_d       = fvalid_q;
          ofd_d       = filt_q;
          oba_d       = best_ang_d;
          obd_d       = best_dist_d;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      win_ang_q   <= '0;
      win_dist_q  <= '0;
      fill_q      <= '0;
      best_ang_q  <= '0;
      best_dist_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_ang_q   <= win_ang_d;
      win_dist_q  <= win_dist_d;
      fill_q      <= fill_d;
      best_ang_q  <= best_ang_d;
      best_dist_q <= best_dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fvalid_q <= fvalid_d;
    filt_q   <= filt_d;
    ofv_q    <= ofv_d;
    ofd_q    <= ofd_d;
    oba_q    <= oba_d;
    obd_q    <= obd_d;
  end

  sosf_sorter u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sort_start),
    .dist_i  (win_dist_q),
    .acc_o   (acc)
  );

  sosf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc.sum),
    .divisor_i  (acc.cnt),
    .div_o      (div)
  );

  assign out_valid_o         = out_valid_q;
  assign filtered_valid_o    = ofv_q;
  assign filtered_distance_o = ofd_q;
  assign best_angle_o        = oba_q;
  assign best_distance_o     = obd_q;

endmodule

`default_nettype wire

FILE: tb/tb_sonar_scan_outlier_filter_core.sv
// Self-checking testbench for sonar_scan_outlier_filter_core: drives sonar samples, predicts each
// filtered result and the running best, and checks every result beat field by field.
// Depends on sosf_pkg and the core, which in turn uses sosf_sorter and sosf_divider.

module tb_sonar_scan_outlier_filter_core;
  import sosf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_ITEMS = 395;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct {
    logic   new_scan;
    angle_t angle;
    dist_t  distance;
  } sonar_sample_t;

  typedef struct {
    logic   filt_valid;
    dist_t  filt_dist;
    angle_t best_ang;
    dist_t  best_dist;
  } filter_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        new_scan_i = 1'b0;
  logic [7:0]  angle_i = '0;
  logic [11:0] distance_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        filtered_valid_o;
  logic [11:0] filtered_distance_o;
  logic [7:0]  best_angle_o;
  logic [11:0] best_distance_o;

  sonar_sample_t  sample_q[$];
  filter_result_t result_q[$];

  // Predictor state: the sample window, its fill level and the best result of the scan.
  angle_t win_ang [WINDOW];
  dist_t  win_dist [WINDOW];
  int     fill_cnt;
  angle_t best_ang;
  dist_t  best_dist;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_full = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;

  sonar_scan_outlier_filter_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .new_scan_i          (new_scan_i),
    .angle_i             (angle_i),
    .distance_i          (distance_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .filtered_valid_o    (filtered_valid_o),
    .filtered_distance_o (filtered_distance_o),
    .best_angle_o        (best_angle_o),
    .best_distance_o     (best_distance_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_scan();
    for (int i = 0; i < WINDOW; i++) begin
      win_ang[i]  = '0;
      win_dist[i] = '0;
    end
    fill_cnt  = 0;
    best_ang  = '0;
    best_dist = '0;
  endfunction

  // Updates the window for one accepted sample and queues the result it must produce.
  function automatic void predict_filter(logic ns, angle_t ang, dist_t dist_in);
    dist_t          srt [WINDOW];
    dist_t          v;
    int             j;
    int             q1;
    int             q3;
    int             lim;
    int             acc;
    int             n;
    filter_result_t r;
    if (ns) begin
      clear_scan();
    end
    if (fill_cnt >= WINDOW) begin
      for (int i = 0; i + 1 < WINDOW; i++) begin
        win_ang[i]  = win_ang[i+1];
        win_dist[i] = win_dist[i+1];
      end
      fill_cnt = WINDOW - 1;
    end
    win_ang[fill_cnt]  = ang;
    win_dist[fill_cnt] = dist_in;
    fill_cnt++;
    r.filt_valid = 1'b0;
    r.filt_dist  = '0;
    if (fill_cnt >= WINDOW) begin
      for (int i = 0; i < WINDOW; i++) srt[i] = win_dist[i];
      for (int i = 1; i < WINDOW; i++) begin
        v = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      q1  = srt[Q1_IDX];
      q3  = srt[Q3_IDX];
      lim = q3 + 2 * (q3 - q1 + 1);
      acc = 0;
      n   = 0;
      for (int i = 0; i < WINDOW; i++) begin
        if (srt[i] <= lim) begin
          acc += srt[i];
          n++;
        end
      end
      r.filt_valid = 1'b1;
      r.filt_dist  = dist_t'(acc / n);
      // Only a strictly larger average displaces the best; ties keep the earlier angle.
      if (r.filt_dist > best_dist) begin
        best_dist = r.filt_dist;
        best_ang  = win_ang[MID_IDX];
      end
    end
    r.best_ang  = best_ang;
    r.best_dist = best_dist;
    result_q.push_back(r);
  endfunction

  // Sender: presents queued samples, holds a stalled beat and idles at random.
  always @(posedge clk_i) begin
    sonar_sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_filter(new_scan_i, angle_i, distance_i);
        n_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = sample_q.pop_front();
        in_valid_i <= 1'b1;
        new_scan_i <= nxt.new_scan;
        angle_i    <= nxt.angle;
        distance_i <= nxt.distance;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker: every accepted result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    filter_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat: valid=%0b filtered=%0d best=%0d@%0d", $time,
                 filtered_valid_o, filtered_distance_o, best_distance_o, best_angle_o);
        n_errors++;
      end else begin
        e = result_q.pop_front();
        if (e.filt_valid) n_full++;
        if (filtered_valid_o !== e.filt_valid) begin
          $display("%0t: filtered_valid expected %0b, got %0b", $time, e.filt_valid,
                   filtered_valid_o);
          n_errors++;
        end
        if (filtered_distance_o !== e.filt_dist) begin
          $display("%0t: filtered_distance expected %0d, got %0d", $time, e.filt_dist,
                   filtered_distance_o);
          n_errors++;
        end
        if (best_angle_o !== e.best_ang) begin
          $display("%0t: best_angle expected %0d, got %0d", $time, e.best_ang, best_angle_o);
          n_errors++;
        end
        if (best_distance_o !== e.best_dist) begin
          $display("%0t: best_distance expected %0d, got %0d", $time, e.best_dist,
                   best_distance_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d samples queued and %0d results outstanding", $time,
               sample_q.size(), result_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_sample(logic ns, int ang, int dist_cm);
    sonar_sample_t s;
    s.new_scan = ns;
    s.angle    = angle_t'(ang);
    s.distance = dist_t'(dist_cm);
    sample_q.push_back(s);
  endtask

  // One servo sweep: a fresh scan, a stepping angle and distances clustered round a base,
  // with the odd random echo thrown in as an outlier.
  task automatic queue_sweep(int len);
    int ang;
    int step;
    int centre;
    int spread;
    int d;
    int a;
    ang  = $urandom_range(0, 180);
    step = $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: centre = $urandom_range(0, 20);
      1: centre = $urandom_range(4000, 4095);
      default: centre = $urandom_range(0, 4095);
    endcase
    case ($urandom_range(0, 2))
      0: spread = 0;
      1: spread = 4;
      default: spread = 60;
    endcase
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        d = $urandom_range(0, 4095);
      end else begin
        d = centre + $urandom_range(0, 2 * spread) - spread;
        if (d < 0) d = 0;
        if (d > 4095) d = 4095;
      end
      a = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : ang;
      push_sample(k == 0, a, d);
      ang += step;
      if (ang > 180) ang -= 181;
    end
  endtask

  task automatic queue_random(int count);
    int queued;
    int len;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(5, 30);
        queue_sweep(len);
      end else begin
        // Unstructured samples, with scan restarts that can cut a window short.
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          push_sample($urandom_range(0, 3) == 0, $urandom_range(0, 255),
                      $urandom_range(0, 4095));
        end
      end
      queued += len;
    end
  endtask

  task automatic queue_directed();
    // Window of extremes: zero and full-scale distances, angles at 0, 180 and beyond range.
    push_sample(1'b1, 0, 0);
    push_sample(1'b0, 180, 4095);
    push_sample(1'b0, 255, 4095);
    push_sample(1'b0, 90, 0);
    push_sample(1'b0, 45, 4095);
    push_sample(1'b0, 1, 0);
    // A restart before the window fills.
    push_sample(1'b1, 10, 100);
    push_sample(1'b0, 11, 102);
    push_sample(1'b0, 12, 101);
    // A tight cluster with one far echo that must be rejected.
    push_sample(1'b1, 20, 200);
    push_sample(1'b0, 21, 201);
    push_sample(1'b0, 22, 199);
    push_sample(1'b0, 23, 200);
    push_sample(1'b0, 24, 4000);
    // Equal average, then lower and higher ones.
    push_sample(1'b0, 25, 200);
    push_sample(1'b0, 26, 150);
    push_sample(1'b0, 27, 3000);
    // A restart on a full window, and all-equal distances.
    push_sample(1'b1, 200, 4095);
    push_sample(1'b0, 170, 4095);
    push_sample(1'b0, 129, 4095);
    push_sample(1'b0, 64, 4095);
    push_sample(1'b0, 3, 4095);
    push_sample(1'b0, 250, 4095);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i || result_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clear_scan();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 65;
    queue_directed();
    queue_random(PHASE_ITEMS - 23);
    drain();

    // The sender holds off here until every result of the previous phase has come back.
    send_idle_pct = 65;
    recv_idle_pct = 30;
    queue_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PHASE_ITEMS);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Sent %0d samples across three handshake mixes; checked %0d results,", n_sent,
             n_results);
    $display("%0d of them on a full window, with %0d mismatches.", n_full, n_errors);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sosf_pkg.sv
sv/sosf_sorter.sv
sv/sosf_divider.sv
sv/sonar_scan_outlier_filter_core.sv
tb/tb_sonar_scan_outlier_filter_core.sv
